// ----- hw/rtl/dmc_pkg.sv -----
// Shared types, register codes, constants and the 2^f table for the DMC walker step.
// Depends on nothing; imported by dmc_walker_step and its testbench.
package dmc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_TAU    = 3'd0;
  localparam logic [2:0] REG_DIFF   = 3'd1;
  localparam logic [2:0] REG_TRIAL  = 3'd2;
  localparam logic [2:0] REG_CHARGE = 3'd3;
  localparam logic [2:0] REG_MAXCP  = 3'd4;
  localparam logic [2:0] REG_NODE   = 3'd5;

  localparam logic [15:0] TAU_RST    = 16'd66;
  localparam logic [15:0] DIFF_RST   = 16'd2072;
  localparam logic [15:0] CHARGE_RST = 16'd256;
  localparam logic [5:0]  MAXCP_RST  = 6'd10;

  // exponent limits and log2(e), all Q.16
  localparam int EXP_HI = 5 * 65536;
  localparam int EXP_LO = -16 * 65536;
  localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

  typedef struct packed {
    logic signed [31:0] old_x;
    logic signed [31:0] old_y;
    logic signed [31:0] old_z;
    logic signed [15:0] noise_x;
    logic signed [15:0] noise_y;
    logic signed [15:0] noise_z;
    logic [15:0]        uniform_sample;
  } walker_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic [5:0]         copy_count;
    logic signed [31:0] new_potential;
    logic               node_killed;
    logic               weight_saturated;
  } result_t;

  // data that rides along the radius and divider stages
  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic               old_pos;
    logic               old_neg;
    logic [15:0]        uniform_sample;
  } side_t;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

  // 2^(i/16) in Q.16
  function automatic logic [17:0] pow2_tab(input logic [4:0] i);
    logic [17:0] r;
    unique case (i)
      5'd0:  r = 18'd65536;
      5'd1:  r = 18'd68438;
      5'd2:  r = 18'd71468;
      5'd3:  r = 18'd74632;
      5'd4:  r = 18'd77936;
      5'd5:  r = 18'd81386;
      5'd6:  r = 18'd84990;
      5'd7:  r = 18'd88752;
      5'd8:  r = 18'd92682;
      5'd9:  r = 18'd96785;
      5'd10: r = 18'd101070;
      5'd11: r = 18'd105546;
      5'd12: r = 18'd110218;
      5'd13: r = 18'd115098;
      5'd14: r = 18'd120194;
      5'd15: r = 18'd125515;
      default: r = 18'd131072;
    endcase
    pow2_tab = r;
  endfunction

endpackage

// ----- hw/rtl/dmc_walker_step.sv -----
// Top level of the DMC walker step: config registers and the full step pipeline.
// Depends on dmc_pkg.
//
// Usage: walker words enter on walker_valid/walker_ready, one result word per walker
// leaves on result_valid/result_ready, in order. Configuration is an APB slave
// (pready tied high, registers at byte addresses 0,4,..,20); write it only while
// the pipeline is empty.
// Throughput: one walker per cycle unless the output stalls (see below). The depth
// is set by the 32-stage bit-per-stage square root and the (2*FRAC_BITS+8)-stage
// restoring divider that form -Z/r, each duplicated for the old and new position.
// All stages advance together; when the result register is full and not taken,
// the whole pipeline and walker_ready hold, so nothing is lost or repeated.
// Reset (rst, synchronous) clears all stage valid bits and loads the register
// defaults; data in flight is dropped.
module dmc_walker_step #(
  parameter int FRAC_BITS = dmc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       walker_valid,
  output logic                       walker_ready,
  input  dmc_pkg::walker_t           walker,
  output logic                       result_valid,
  input  logic                       result_ready,
  output dmc_pkg::result_t           result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dmc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import dmc_pkg::*;

  localparam int SHIFT = 28 - FRAC_BITS;
  localparam int NUM_W = 2 * FRAC_BITS + 8;
  localparam int XQ_W  = 51 - FRAC_BITS;

  // ---------------- config ----------------
  logic [15:0]        tau_step;
  logic [15:0]        diffusion_step;
  logic signed [31:0] trial_energy;
  logic [15:0]        nuclear_charge;
  logic [5:0]         max_copies;
  logic               node_mode;
  logic               wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tau_step       <= TAU_RST;
      diffusion_step <= DIFF_RST;
      trial_energy   <= '0;
      nuclear_charge <= CHARGE_RST;
      max_copies     <= MAXCP_RST;
      node_mode      <= 1'b0;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_TAU:    tau_step       <= pwdata[15:0];
        REG_DIFF:   diffusion_step <= pwdata[15:0];
        REG_TRIAL:  trial_energy   <= pwdata;
        REG_CHARGE: nuclear_charge <= pwdata[15:0];
        REG_MAXCP:  max_copies     <= pwdata[5:0];
        REG_NODE:   node_mode      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_TAU:    prdata = {16'b0, tau_step};
      REG_DIFF:   prdata = {16'b0, diffusion_step};
      REG_TRIAL:  prdata = trial_energy;
      REG_CHARGE: prdata = {16'b0, nuclear_charge};
      REG_MAXCP:  prdata = {26'b0, max_copies};
      REG_NODE:   prdata = {31'b0, node_mode};
      default:    prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic adv;
  assign adv = ~result_valid | result_ready;
  assign walker_ready = adv;

  // ---------------- front: move and squares ----------------
  logic               v1, v2, v3, v4, v5;
  walker_t            w1, w2;
  logic signed [32:0] p2 [3];
  logic signed [31:0] o3 [3];
  side_t              side3, side4, s5_side;
  logic [63:0]        osq4 [3];
  logic [63:0]        nsq4 [3];
  logic [63:0]        s5_sum [2];

  logic signed [15:0] noise1 [3];
  logic signed [31:0] old2 [3];
  logic signed [31:0] new3 [3];
  logic signed [31:0] new_c [3];

  assign noise1[0] = w1.noise_x;
  assign noise1[1] = w1.noise_y;
  assign noise1[2] = w1.noise_z;
  assign old2[0] = w2.old_x;
  assign old2[1] = w2.old_y;
  assign old2[2] = w2.old_z;
  assign new3[0] = side3.new_x;
  assign new3[1] = side3.new_y;
  assign new3[2] = side3.new_z;

  always_comb begin
    logic signed [32:0] d;
    logic signed [33:0] s;
    for (int j = 0; j < 3; j++) begin
      d = (p2[j] + (33'sd1 <<< (SHIFT - 1))) >>> SHIFT;
      s = {{2{old2[j][31]}}, old2[j]} + {d[32], d};
      if (s > 34'sh0_7FFF_FFFF)       new_c[j] = 32'sh7FFF_FFFF;
      else if (s < -34'sh0_8000_0000) new_c[j] = 32'sh8000_0000;
      else                            new_c[j] = s[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (adv) begin
      v1 <= walker_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1 <= walker;
      w2 <= w1;
      for (int j = 0; j < 3; j++) begin
        p2[j]   <= $signed({1'b0, diffusion_step}) * noise1[j];
        o3[j]   <= old2[j];
        osq4[j] <= abs32(o3[j]) * abs32(o3[j]);
        nsq4[j] <= abs32(new3[j]) * abs32(new3[j]);
      end
      side3.new_x          <= new_c[0];
      side3.new_y          <= new_c[1];
      side3.new_z          <= new_c[2];
      side3.old_pos        <= ~w2.old_z[31] & (w2.old_z != '0);
      side3.old_neg        <= w2.old_z[31];
      side3.uniform_sample <= w2.uniform_sample;
      side4     <= side3;
      s5_sum[0] <= osq4[0] + osq4[1] + osq4[2];
      s5_sum[1] <= nsq4[0] + nsq4[1] + nsq4[2];
      s5_side   <= side4;
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  logic [63:0] sq_n   [32][2];
  logic [32:0] sq_rem [32][2];
  logic [31:0] sq_rt  [32][2];
  side_t       sq_side [32];
  logic        sq_v    [32];

  for (genvar k = 0; k < 32; k++) begin : g_sqrt
    logic [63:0] n_in   [2];
    logic [32:0] rem_in [2];
    logic [31:0] rt_in  [2];
    side_t       side_in;
    logic        v_in;

    if (k == 0) begin : g_first
      always_comb begin
        for (int j = 0; j < 2; j++) begin
          n_in[j]   = s5_sum[j];
          rem_in[j] = '0;
          rt_in[j]  = '0;
        end
        side_in = s5_side;
        v_in    = v5;
      end
    end else begin : g_next
      always_comb begin
        for (int j = 0; j < 2; j++) begin
          n_in[j]   = sq_n[k-1][j];
          rem_in[j] = sq_rem[k-1][j];
          rt_in[j]  = sq_rt[k-1][j];
        end
        side_in = sq_side[k-1];
        v_in    = sq_v[k-1];
      end
    end

    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [34:0] rem_sh;
      logic [34:0] trial;
      logic        take;
      assign rem_sh = {rem_in[j], n_in[j][63:62]};
      assign trial  = {1'b0, rt_in[j], 2'b01};
      assign take   = rem_sh >= trial;
      always_ff @(posedge clk) begin
        if (adv) begin
          sq_n[k][j]   <= {n_in[j][61:0], 2'b00};
          sq_rem[k][j] <= take ? 33'(rem_sh - trial) : rem_sh[32:0];
          sq_rt[k][j]  <= {rt_in[j][30:0], take};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) sq_side[k] <= side_in;
    end
    always_ff @(posedge clk) begin
      if (rst) sq_v[k] <= 1'b0;
      else if (adv) sq_v[k] <= v_in;
    end
  end

  // ---------------- restoring divide (Z << (2F-8)) / r ----------------
  logic [NUM_W-1:0] num_word;
  logic [31:0]      dv_rem [NUM_W][2];
  logic [NUM_W-1:0] dv_q   [NUM_W][2];
  logic [31:0]      dv_r   [NUM_W][2];
  logic             dv_z   [NUM_W][2];
  side_t            dv_side [NUM_W];
  logic             dv_v    [NUM_W];

  assign num_word = {nuclear_charge, {(2 * FRAC_BITS - 8){1'b0}}};

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    logic [31:0]      rem_in [2];
    logic [NUM_W-1:0] q_in   [2];
    logic [31:0]      r_in   [2];
    logic             z_in   [2];
    side_t            side_in;
    logic             v_in;

    if (k == 0) begin : g_first
      always_comb begin
        for (int j = 0; j < 2; j++) begin
          rem_in[j] = '0;
          q_in[j]   = '0;
          r_in[j]   = sq_rt[31][j];
          z_in[j]   = sq_rt[31][j] == '0;
        end
        side_in = sq_side[31];
        v_in    = sq_v[31];
      end
    end else begin : g_next
      always_comb begin
        for (int j = 0; j < 2; j++) begin
          rem_in[j] = dv_rem[k-1][j];
          q_in[j]   = dv_q[k-1][j];
          r_in[j]   = dv_r[k-1][j];
          z_in[j]   = dv_z[k-1][j];
        end
        side_in = dv_side[k-1];
        v_in    = dv_v[k-1];
      end
    end

    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic [32:0] rem_sh;
      logic        take;
      assign rem_sh = {rem_in[j], num_word[NUM_W-1-k]};
      assign take   = rem_sh >= {1'b0, r_in[j]};
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem[k][j] <= take ? 32'(rem_sh - {1'b0, r_in[j]}) : rem_sh[31:0];
          dv_q[k][j]   <= {q_in[j][NUM_W-2:0], take};
          dv_r[k][j]   <= r_in[j];
          dv_z[k][j]   <= z_in[j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) dv_side[k] <= side_in;
    end
    always_ff @(posedge clk) begin
      if (rst) dv_v[k] <= 1'b0;
      else if (adv) dv_v[k] <= v_in;
    end
  end

  // ---------------- energy, exponent, weight, copies ----------------
  logic               vp, ve1, ve2, ve3, ve4, ve5, ve6;
  side_t              sp, se1, se2, se3, se4, se5, se6;
  logic signed [31:0] pot [2];
  logic signed [31:0] pe1, pe2, pe3, pe4, pe5, pe6;
  logic signed [31:0] e1;
  logic signed [49:0] t2;
  logic               hi3, lo3, hi4, lo4, hi5, lo5, hi6, lo6;
  logic signed [21:0] xq3;
  logic signed [39:0] prod4;
  logic [17:0]        m5;
  logic signed [7:0]  n5;
  logic [10:0]        cnt6;

  logic signed [31:0] pot_c [2];
  logic signed [32:0] esum;
  logic signed [32:0] ediff;
  logic signed [50:0] neg_t;
  logic signed [XQ_W-1:0] xq_full;
  logic signed [23:0] y4;
  logic [3:0]         idx;
  logic [11:0]        lo_f;
  logic [17:0]        tab_a, tab_b;
  logic [24:0]        interp;
  logic [25:0]        w5;
  logic [7:0]         nneg;
  logic [26:0]        wsum;

  always_comb begin
    logic [63:0] q64;
    for (int j = 0; j < 2; j++) begin
      q64 = 64'(dv_q[NUM_W-1][j]);
      if (dv_z[NUM_W-1][j] || q64 > 64'h8000_0000) pot_c[j] = 32'sh8000_0000;
      else                                          pot_c[j] = 32'(-q64);
    end
  end

  assign esum    = {pot[0][31], pot[0]} + {pot[1][31], pot[1]};
  assign ediff   = {e1[31], e1} - {trial_energy[31], trial_energy};
  assign neg_t   = 51'sd0 - {t2[49], t2};
  assign xq_full = XQ_W'(neg_t >>> FRAC_BITS);
  assign y4      = prod4[39:16];
  assign idx     = y4[15:12];
  assign lo_f    = y4[11:0];
  assign tab_a   = pow2_tab({1'b0, idx});
  assign tab_b   = pow2_tab(5'({1'b0, idx}) + 5'd1);
  assign interp  = 13'(tab_b - tab_a) * lo_f;
  assign nneg    = 8'(-n5);
  assign w5      = n5[7] ? (26'(m5) >> nneg[4:0]) : (26'(m5) << n5[2:0]);
  assign wsum    = 27'(w5) + 27'(se5.uniform_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0; ve1 <= 1'b0; ve2 <= 1'b0; ve3 <= 1'b0;
      ve4 <= 1'b0; ve5 <= 1'b0; ve6 <= 1'b0;
    end else if (adv) begin
      vp <= dv_v[NUM_W-1]; ve1 <= vp; ve2 <= ve1; ve3 <= ve2;
      ve4 <= ve3; ve5 <= ve4; ve6 <= ve5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pot[0] <= pot_c[0];
      pot[1] <= pot_c[1];
      sp     <= dv_side[NUM_W-1];
      e1  <= esum[32:1];
      pe1 <= pot[1];
      se1 <= sp;
      t2  <= $signed({1'b0, tau_step}) * ediff;
      pe2 <= pe1;
      se2 <= se1;
      hi3 <= xq_full >= XQ_W'(EXP_HI);
      lo3 <= xq_full < XQ_W'(EXP_LO);
      xq3 <= xq_full[21:0];
      pe3 <= pe2;
      se3 <= se2;
      prod4 <= xq3 * LOG2E_Q16;
      hi4 <= hi3; lo4 <= lo3; pe4 <= pe3; se4 <= se3;
      m5  <= tab_a + 18'(interp[24:12]);
      n5  <= y4[23:16];
      hi5 <= hi4; lo5 <= lo4; pe5 <= pe4; se5 <= se4;
      cnt6 <= wsum[26:16];
      hi6 <= hi5; lo6 <= lo5; pe6 <= pe5; se6 <= se5;
    end
  end

  // ---------------- result register ----------------
  logic    crossed;
  logic [10:0] cnt_m;
  result_t res_c;

  assign crossed = (se6.old_pos & se6.new_z[31]) |
                   (se6.old_neg & ~se6.new_z[31] & (se6.new_z != '0));
  assign cnt_m = lo6 ? 11'd0 : cnt6;

  always_comb begin
    res_c.new_x            = se6.new_x;
    res_c.new_y            = se6.new_y;
    res_c.new_z            = se6.new_z;
    res_c.new_potential    = pe6;
    res_c.node_killed      = 1'b0;
    res_c.weight_saturated = 1'b0;
    res_c.copy_count       = 6'(cnt_m);
    if (node_mode && crossed) begin
      res_c.copy_count  = '0;
      res_c.node_killed = 1'b1;
    end else if (hi6) begin
      res_c.copy_count       = max_copies;
      res_c.weight_saturated = max_copies != '0;
    end else if (cnt_m > {5'b0, max_copies}) begin
      res_c.copy_count       = max_copies;
      res_c.weight_saturated = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (adv) result_valid <= ve6;
  end

  always_ff @(posedge clk) begin
    if (adv) result <= res_c;
  end

endmodule

// ----- verif/dmc_walker_step_test.sv -----
// Self-checking testbench for dmc_walker_step: random and directed walker words,
// APB register phases, and a bit-exact predictor of the step. Depends on dmc_pkg.
`timescale 1ns / 1ps

module dmc_walker_step_test;
  import dmc_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 53 + 2 * FB;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic walker_valid = 1'b0;
  logic walker_ready;
  walker_t walker = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dmc_walker_step dut (.*);

  // register shadow
  logic [15:0] tau_q, diff_q, charge_q;
  logic signed [31:0] trial_q;
  logic [5:0] maxcp_q;
  logic node_q;

  walker_t pending_words[$];
  result_t expected_results[$];
  int errors = 0;
  int sent = 0;
  int send_gap = 0;
  int take_gap = 0;
  bit quiet_send = 0;
  bit quiet_take = 0;

  localparam longint POW2[17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990,
    88752, 92682, 96785, 101070, 105546, 110218, 115098, 120194, 125515, 131072};

  initial forever #10 clk = ~clk;

  initial begin
    #50_000_000;
    $display("dmc_walker_step verification failed");
    $finish;
  end

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint moved(longint pos, longint noise);
    longint p;
    p = longint'(diff_q) * noise;
    return sat32(pos + fshr(p + (64'sd1 << (28 - FB - 1)), 28 - FB));
  endfunction

  function automatic longint isqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint potential(longint x, longint y, longint z);
    logic [63:0] ax, ay, az, r, q;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    r = isqrt(ax * ax + ay * ay + az * az);
    if (r == 0) return -64'sd2147483648;
    q = (64'(charge_q) << (2 * FB - 8)) / r;
    if (q > 64'd2147483648) return -64'sd2147483648;
    return -longint'(q);
  endfunction

  function automatic longint exp2w(longint xq);
    longint y, n, f, lo, m;
    int idx;
    y = fshr(xq * 94548, 16);
    n = fshr(y, 16);
    f = y - n * 65536;
    idx = int'((f >> 12) & 15);
    lo = f & 12'hfff;
    m = POW2[idx] + fshr((POW2[idx + 1] - POW2[idx]) * lo, 12);
    return n >= 0 ? m << n : fshr(m, int'(-n));
  endfunction

  function automatic result_t step_walker(walker_t w);
    result_t o;
    longint ox, oy, oz, nx, ny, nz, va, vb, e, t, xq, wt, m;
    ox = w.old_x; oy = w.old_y; oz = w.old_z;
    nx = moved(ox, longint'(w.noise_x));
    ny = moved(oy, longint'(w.noise_y));
    nz = moved(oz, longint'(w.noise_z));
    va = potential(ox, oy, oz);
    vb = potential(nx, ny, nz);
    e = fshr(va + vb, 1);
    t = longint'(tau_q) * (e - longint'(trial_q));
    xq = fshr(-t, FB);
    o = '0;
    o.new_x = nx[31:0];
    o.new_y = ny[31:0];
    o.new_z = nz[31:0];
    o.new_potential = vb[31:0];
    if (node_q && ((oz > 0 && nz < 0) || (oz < 0 && nz > 0))) begin
      o.node_killed = 1'b1;
    end else if (xq >= EXP_HI) begin
      o.copy_count = maxcp_q;
      o.weight_saturated = maxcp_q != 0;
    end else begin
      wt = xq < EXP_LO ? 64'sd0 : exp2w(xq);
      m = (wt + longint'(w.uniform_sample)) >>> 16;
      if (m > longint'(maxcp_q)) begin
        m = longint'(maxcp_q);
        o.weight_saturated = 1'b1;
      end
      o.copy_count = m[5:0];
    end
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic queue_word(walker_t w);
    pending_words = {pending_words, w};
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      walker_valid <= 1'b0;
    end else if (!walker_valid || walker_ready) begin
      if (walker_valid) begin
        expected_results = {expected_results, step_walker(walker)};
        sent++;
        send_gap = quiet_send ? 0 : $urandom_range(0, 10);
      end
      if (send_gap > 0) begin
        send_gap--;
        walker_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        walker <= pending_words.pop_front();
        walker_valid <= 1'b1;
      end else begin
        walker_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected word", 64'(result), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (result.new_x !== want.new_x)
            report("new_x", 64'(result.new_x), 64'(want.new_x));
          if (result.new_y !== want.new_y)
            report("new_y", 64'(result.new_y), 64'(want.new_y));
          if (result.new_z !== want.new_z)
            report("new_z", 64'(result.new_z), 64'(want.new_z));
          if (result.copy_count !== want.copy_count)
            report("copy_count", 64'(result.copy_count), 64'(want.copy_count));
          if (result.new_potential !== want.new_potential)
            report("new_potential", 64'(result.new_potential), 64'(want.new_potential));
          if (result.node_killed !== want.node_killed)
            report("node_killed", 64'(result.node_killed), 64'(want.node_killed));
          if (result.weight_saturated !== want.weight_saturated)
            report("weight_saturated", 64'(result.weight_saturated),
                   64'(want.weight_saturated));
        end
        take_gap = quiet_take ? 0 : $urandom_range(0, 10);
      end
      if (take_gap > 0) begin
        take_gap--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    unique case (idx)
      REG_TAU:    tau_q = val[15:0];
      REG_DIFF:   diff_q = val[15:0];
      REG_TRIAL:  trial_q = val;
      REG_CHARGE: charge_q = val[15:0];
      REG_MAXCP:  maxcp_q = val[5:0];
      REG_NODE:   node_q = val[0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [15:0] tau, logic [15:0] diff, logic [31:0] trial,
                       logic [15:0] charge, logic [5:0] maxcp, logic node);
    reg_write(REG_TAU, 32'(tau));
    reg_write(REG_DIFF, 32'(diff));
    reg_write(REG_TRIAL, trial);
    reg_write(REG_CHARGE, 32'(charge));
    reg_write(REG_MAXCP, 32'(maxcp));
    reg_write(REG_NODE, 32'(node));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_words.size() > 0 || walker_valid || expected_results.size() > 0)
           && guard < 2_000_000) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= 2_000_000) begin
      $display("dmc_walker_step verification failed");
      $finish;
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic walker_t mk(int x, int y, int z, shortint nx, shortint ny,
                                 shortint nz, logic [15:0] u);
    walker_t w;
    w.old_x = x; w.old_y = y; w.old_z = z;
    w.noise_x = nx; w.noise_y = ny; w.noise_z = nz;
    w.uniform_sample = u;
    return w;
  endfunction

  function automatic logic [31:0] rpos();
    unique case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return 32'(int'($urandom_range(0, 512)) - 256);
      3: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      4: return $urandom_range(0, 1) ? 32'h7fff_ff00 + $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      default: return 32'(int'($urandom_range(0, 64 << 16)) - (32 << 16));
    endcase
  endfunction

  function automatic walker_t rand_walker();
    return mk(rpos(), rpos(), rpos(), 16'($urandom), 16'($urandom),
              $urandom_range(0, 3) == 0 ? 16'($urandom)
                                        : 16'(int'($urandom_range(0, 16384)) - 8192),
              16'($urandom));
  endfunction

  task automatic random_phase(int n);
    quiet_send = $urandom_range(0, 3) == 0;
    quiet_take = $urandom_range(0, 3) == 0;
    repeat (n) queue_word(rand_walker());
    drain();
  endtask

  initial begin
    tau_q = TAU_RST; diff_q = DIFF_RST; trial_q = 0; charge_q = CHARGE_RST;
    maxcp_q = MAXCP_RST; node_q = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // directed, reset defaults first
    queue_word(mk(0, 0, 0, 0, 0, 0, 0));
    queue_word(mk(0, 0, 0, 16'sh7fff, 16'sh8000, 0, 16'hffff));
    queue_word(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  16'sh7fff, 16'sh8000, 16'sh7fff, 16'hffff));
    queue_word(mk(1 << 16, 0, 0, 0, 0, 0, 16'h8000));
    queue_word(mk(1, 0, 0, 0, 0, 0, 0));
    queue_word(mk(0, 0, 100, 0, 0, -16'sd4096, 16'h1234));
    drain();
    setup(16'hffff, 16'hffff, 32'h7fffffff, 16'hffff, 6'd63, 1'b1);
    queue_word(mk(0, 0, 1 << 10, 0, 0, -16'sd4096, 0));
    queue_word(mk(0, 0, -(1 << 10), 0, 0, 16'sd4096, 16'hffff));
    queue_word(mk(5 << 16, 0, 1 << 16, 0, 0, 0, 16'hffff));
    queue_word(mk(0, 0, 0, 0, 0, 0, 0));
    drain();
    setup(16'd1, 16'd1, 32'h80000000, 16'd0, 6'd1, 1'b0);
    queue_word(mk(0, 0, 0, 16'sh7fff, 0, 0, 16'hffff));
    queue_word(mk(1 << 16, 1 << 16, 1 << 16, 0, 0, 0, 0));
    drain();
    setup(16'd0, 16'd0, 32'd0, 16'd256, 6'd0, 1'b1);
    queue_word(mk(1 << 16, 0, 1, 16'sh8000, 0, 16'sh8000, 16'hffff));
    queue_word(mk(1 << 16, 0, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      unique case (ph % 5)
        0: setup(TAU_RST, DIFF_RST, 32'(-($urandom_range(0, 3) << 16)), CHARGE_RST,
                 MAXCP_RST, ph[0]);
        1: setup(16'($urandom), 16'($urandom), $urandom, 16'($urandom), 6'($urandom),
                 ph[0]);
        2: setup(16'hffff, 16'hffff, $urandom, 16'hffff, 6'd63, ph[0]);
        3: setup(16'd1, 16'd1, 32'h80000000, 16'd0, 6'd1, ph[0]);
        default: setup(16'($urandom_range(1, 4000)), 16'($urandom_range(1, 20000)),
                       32'(-int'($urandom_range(0, 1 << 17))),
                       16'($urandom_range(0, 2048)), 6'($urandom_range(1, 63)), ph[0]);
      endcase
      random_phase(175);
    end

    if (errors == 0) begin
      $display("dmc_walker_step verification clean");
    end else begin
      $display("dmc_walker_step verification failed");
    end
    $finish;
  end

endmodule
